// File: hw/rtl/turn_then_move_waypoint_follower_defines.svh
// ----------------------------------------------------------------------------
// turn_then_move_waypoint_follower assertion macros
// shared property forms for the follower's checks
// ----------------------------------------------------------------------------
`ifndef TURN_THEN_MOVE_WAYPOINT_FOLLOWER_DEFINES_SVH
`define TURN_THEN_MOVE_WAYPOINT_FOLLOWER_DEFINES_SVH

// same-cycle implication
`define TTM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ttm_pkg.sv
// ----------------------------------------------------------------------------
// ttm_pkg
// word types, codes and tables of the waypoint follower
// ----------------------------------------------------------------------------
package ttm_pkg;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic [15:0]        turn_step;
      logic [30:0]        move_step;
      logic [15:0]        new_heading;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        heading;
      logic               arrived;
   } rsp_type;

   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_SET_POS = 2'd1;
   localparam logic [1:0] KIND_SET_DST = 2'd2;
   localparam logic [1:0] KIND_SET_HDG = 2'd3;

   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] CORDIC_LAST = 6'd17;
   localparam logic [CNT_W-1:0] SQRT_LAST   = 6'd33;
   localparam logic [CNT_W-1:0] DIV_LAST    = 6'd31;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_EXEC,
      OP_HDG_INIT,
      OP_HDG_NORM,
      OP_HDG_FLIP,
      OP_HDG_ITER,
      OP_HDG_WRITE,
      OP_TURN,
      OP_DIFF,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQ_S,
      OP_SNAP,
      OP_SQRT_INIT,
      OP_SQRT,
      OP_DIV_MUL_X,
      OP_DIV_MUL_Y,
      OP_DIV_INIT,
      OP_DIV,
      OP_ADD_X,
      OP_ADD_Y,
      OP_OUT
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HDG_INIT,
      ST_HDG_NORM,
      ST_HDG_ITER,
      ST_HDG_WRITE,
      ST_TURN,
      ST_ALIGN,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_S,
      ST_SNAP,
      ST_SQRT,
      ST_DIV_MUL_X,
      ST_DIV_INIT_X,
      ST_DIV_X,
      ST_ADD_X,
      ST_DIV_MUL_Y,
      ST_DIV_INIT_Y,
      ST_DIV_Y,
      ST_ADD_Y,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic             arrived;
      logic             aligned;
      logic             big;
      logic             snap;
      logic             norm_zero;
      logic [CNT_W-1:0] cnt;
   } status_type;

   // cordic angle table, 2^32 per turn
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'h2000_0000;
         5'd1:    val = 32'h12E4_051D;
         5'd2:    val = 32'h09FB_385B;
         5'd3:    val = 32'h0511_11D4;
         5'd4:    val = 32'h028B_0D43;
         5'd5:    val = 32'h0145_D7E1;
         5'd6:    val = 32'h00A2_F61E;
         5'd7:    val = 32'h0051_7C55;
         5'd8:    val = 32'h0028_BE53;
         5'd9:    val = 32'h0014_5F2E;
         5'd10:   val = 32'h000A_2F98;
         5'd11:   val = 32'h0005_17CC;
         5'd12:   val = 32'h0002_8BE6;
         5'd13:   val = 32'h0001_45F3;
         5'd14:   val = 32'h0000_A2F9;
         5'd15:   val = 32'h0000_517C;
         5'd16:   val = 32'h0000_28BE;
         5'd17:   val = 32'h0000_145F;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

// File: hw/rtl/ttm_dp.sv
// ----------------------------------------------------------------------------
// ttm_dp
// follower state, cordic, multiplier, square root and divider datapath
// ----------------------------------------------------------------------------
module ttm_dp (
   input  logic                clock,
   input  logic                reset,
   input  ttm_pkg::req_type    req_data,
   input  ttm_pkg::cmd_type    cmd,
   output ttm_pkg::status_type status,
   output ttm_pkg::rsp_type    rsp_data
);
   import ttm_pkg::*;

   localparam int CW = 46;
   localparam logic signed [CW-1:0] LIM_POS = 46'sh100_0000_0000;
   localparam logic signed [CW-1:0] LIM_NEG = -LIM_POS;

   req_type            item_ff, item_in;
   rsp_type            rsp_ff, rsp_in;
   logic signed [31:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [31:0] dst_x_ff, dst_x_in, dst_y_ff, dst_y_in;
   logic [15:0]        cur_hdg_ff, cur_hdg_in, dst_hdg_ff, dst_hdg_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [31:0]        z_ff, z_in;
   logic [31:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic               negx_ff, negx_in, negy_ff, negy_in;
   logic [63:0]        prod_ff, prod_in;
   logic [67:0]        sum_ff, sum_in;
   logic [33:0]        root_ff, root_in;
   logic [34:0]        srem_ff, srem_in;
   logic [34:0]        drem_ff, drem_in;
   logic [31:0]        dq_ff, dq_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic signed [32:0]   dx, dy;
   logic signed [CW-1:0] dx_ext, dy_ext, xs, ys;
   logic [32:0]          dx_mag, dy_mag;
   logic [31:0]          mul_a, mul_b, step32, z_round;
   logic [63:0]          mul_p;
   logic                 cy_pos;
   logic [16:0]          t_c, t_d, t_step, t_ad, t_res;
   logic [36:0]          sq_rem2, sq_trial;
   logic [34:0]          dv_rem2;

   assign dx     = {dst_x_ff[31], dst_x_ff} - {cur_x_ff[31], cur_x_ff};
   assign dy     = {dst_y_ff[31], dst_y_ff} - {cur_y_ff[31], cur_y_ff};
   assign dx_ext = {{(CW-33){dx[32]}}, dx};
   assign dy_ext = {{(CW-33){dy[32]}}, dy};
   assign dx_mag = dx[32] ? -dx : dx;
   assign dy_mag = dy[32] ? -dy : dy;
   assign step32 = {1'b0, item_ff.move_step};

   // cordic
   assign xs      = cx_ff >>> cnt_ff[4:0];
   assign ys      = cy_ff >>> cnt_ff[4:0];
   assign cy_pos  = !cy_ff[CW-1] && (cy_ff != '0);
   assign z_round = z_ff + 32'h0000_8000;

   // turn toward destination heading
   assign t_c    = {1'b0, cur_hdg_ff};
   assign t_d    = {1'b0, dst_hdg_ff};
   assign t_step = {1'b0, item_ff.turn_step};
   assign t_ad   = (t_d >= t_c) ? (t_d - t_c) : (t_c - t_d);

   always_comb begin
      if (t_ad <= 17'd32768) begin
         if (t_ad < t_step) begin
            t_res = t_d;
         end else begin
            t_res = (t_d > t_c) ? (t_c + t_step) : (t_c - t_step);
         end
      end else begin
         if ((17'h10000 - t_ad) < t_step) begin
            t_res = t_d;
         end else begin
            t_res = (t_d > t_c) ? (t_c - t_step) : (t_c + t_step);
         end
      end
   end

   // shared multiplier
   always_comb begin
      case (cmd.op)
         OP_SQ_X: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         OP_SQ_Y: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         OP_SQ_S: begin
            mul_a = step32;
            mul_b = step32;
         end
         OP_DIV_MUL_X: begin
            mul_a = ax_ff;
            mul_b = step32;
         end
         OP_DIV_MUL_Y: begin
            mul_a = ay_ff;
            mul_b = step32;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // one root bit and one quotient bit per step
   assign sq_rem2  = {srem_ff, sum_ff[67:66]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign dv_rem2  = {drem_ff[33:0], dq_ff[31]};

   always_comb begin
      item_in    = item_ff;
      rsp_in     = rsp_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      dst_x_in   = dst_x_ff;
      dst_y_in   = dst_y_ff;
      cur_hdg_in = cur_hdg_ff;
      dst_hdg_in = dst_hdg_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      z_in       = z_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      negx_in    = negx_ff;
      negy_in    = negy_ff;
      prod_in    = prod_ff;
      sum_in     = sum_ff;
      root_in    = root_ff;
      srem_in    = srem_ff;
      drem_in    = drem_ff;
      dq_in      = dq_ff;
      cnt_in     = cnt_ff;
      case (cmd.op)
         OP_LOAD: begin
            item_in = req_data;
         end
         OP_EXEC: begin
            case (item_ff.kind)
               KIND_SET_POS: begin
                  cur_x_in = item_ff.coord_x;
                  cur_y_in = item_ff.coord_y;
               end
               KIND_SET_DST: begin
                  dst_x_in = item_ff.coord_x;
                  dst_y_in = item_ff.coord_y;
               end
               KIND_SET_HDG: begin
                  cur_hdg_in = item_ff.new_heading;
                  dst_hdg_in = item_ff.new_heading;
                  dst_x_in   = cur_x_ff;
                  dst_y_in   = cur_y_ff;
               end
               default: begin
               end
            endcase
         end
         OP_HDG_INIT: begin
            cx_in = dy_ext;
            cy_in = -dx_ext;
         end
         OP_HDG_NORM: begin
            cx_in = cx_ff <<< 1;
            cy_in = cy_ff <<< 1;
         end
         OP_HDG_FLIP: begin
            cnt_in = '0;
            if (cx_ff[CW-1]) begin
               cx_in = -cx_ff;
               cy_in = -cy_ff;
               z_in  = 32'h8000_0000;
            end else begin
               z_in  = 32'h0000_0000;
            end
         end
         OP_HDG_ITER: begin
            cnt_in = cnt_ff + 1'b1;
            if (cy_pos) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               z_in  = z_ff + atan_entry(cnt_ff[4:0]);
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               z_in  = z_ff - atan_entry(cnt_ff[4:0]);
            end
         end
         OP_HDG_WRITE: begin
            dst_hdg_in = z_round[31:16];
         end
         OP_TURN: begin
            cur_hdg_in = t_res[15:0];
         end
         OP_DIFF: begin
            ax_in   = dx_mag[31:0];
            ay_in   = dy_mag[31:0];
            negx_in = dx[32];
            negy_in = dy[32];
         end
         OP_SQ_X: begin
            prod_in = mul_p;
         end
         OP_SQ_Y: begin
            sum_in  = {4'b0, prod_ff};
            prod_in = mul_p;
         end
         OP_SQ_S: begin
            sum_in  = sum_ff + {4'b0, prod_ff};
            prod_in = mul_p;
         end
         OP_SNAP: begin
            cur_x_in = dst_x_ff;
            cur_y_in = dst_y_ff;
         end
         OP_SQRT_INIT: begin
            root_in = '0;
            srem_in = '0;
            cnt_in  = '0;
         end
         OP_SQRT: begin
            cnt_in = cnt_ff + 1'b1;
            sum_in = {sum_ff[65:0], 2'b00};
            if (sq_rem2 >= sq_trial) begin
               srem_in = 35'(sq_rem2 - sq_trial);
               root_in = {root_ff[32:0], 1'b1};
            end else begin
               srem_in = sq_rem2[34:0];
               root_in = {root_ff[32:0], 1'b0};
            end
         end
         OP_DIV_MUL_X, OP_DIV_MUL_Y: begin
            prod_in = mul_p;
         end
         OP_DIV_INIT: begin
            drem_in = {4'b0, prod_ff[62:32]};
            dq_in   = prod_ff[31:0];
            cnt_in  = '0;
         end
         OP_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (dv_rem2 >= {1'b0, root_ff}) begin
               drem_in = dv_rem2 - {1'b0, root_ff};
               dq_in   = {dq_ff[30:0], 1'b1};
            end else begin
               drem_in = dv_rem2;
               dq_in   = {dq_ff[30:0], 1'b0};
            end
         end
         OP_ADD_X: begin
            cur_x_in = negx_ff ? $signed($unsigned(cur_x_ff) - dq_ff)
                               : $signed($unsigned(cur_x_ff) + dq_ff);
         end
         OP_ADD_Y: begin
            cur_y_in = negy_ff ? $signed($unsigned(cur_y_ff) - dq_ff)
                               : $signed($unsigned(cur_y_ff) + dq_ff);
         end
         OP_OUT: begin
            rsp_in.pos_x   = cur_x_ff;
            rsp_in.pos_y   = cur_y_ff;
            rsp_in.heading = cur_hdg_ff;
            rsp_in.arrived = status.arrived;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         dst_x_ff   <= '0;
         dst_y_ff   <= '0;
         cur_hdg_ff <= '0;
         dst_hdg_ff <= '0;
      end else begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         dst_x_ff   <= dst_x_in;
         dst_y_ff   <= dst_y_in;
         cur_hdg_ff <= cur_hdg_in;
         dst_hdg_ff <= dst_hdg_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      negx_ff <= negx_in;
      negy_ff <= negy_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
      drem_ff <= drem_in;
      dq_ff   <= dq_in;
      cnt_ff  <= cnt_in;
   end

   assign status.kind      = item_ff.kind;
   assign status.arrived   = (cur_x_ff == dst_x_ff) && (cur_y_ff == dst_y_ff);
   assign status.aligned   = (cur_hdg_ff == dst_hdg_ff);
   assign status.big       = !((cx_ff < LIM_POS) && (cx_ff > LIM_NEG) &&
                               (cy_ff < LIM_POS) && (cy_ff > LIM_NEG));
   assign status.snap      = (sum_ff < {4'b0, prod_ff});
   assign status.norm_zero = (root_ff == '0);
   assign status.cnt       = cnt_ff;

   assign rsp_data = rsp_ff;

endmodule

// File: hw/rtl/ttm_ctrl.sv
// ----------------------------------------------------------------------------
// ttm_ctrl
// sequencer for set, turn and move steps, and the result valid register
// ----------------------------------------------------------------------------
`include "turn_then_move_waypoint_follower_defines.svh"

module ttm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ttm_pkg::status_type status,
   output ttm_pkg::cmd_type    cmd
);
   import ttm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.op = OP_EXEC;
            case (status.kind)
               KIND_TICK: begin
                  state_in = status.arrived ? ST_FINISH : ST_TURN;
               end
               KIND_SET_POS, KIND_SET_DST: begin
                  state_in = ST_HDG_INIT;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_HDG_INIT: begin
            if (status.arrived) begin
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_HDG_INIT;
               state_in = ST_HDG_NORM;
            end
         end
         ST_HDG_NORM: begin
            if (status.big) begin
               cmd.op   = OP_HDG_FLIP;
               state_in = ST_HDG_ITER;
            end else begin
               cmd.op = OP_HDG_NORM;
            end
         end
         ST_HDG_ITER: begin
            cmd.op = OP_HDG_ITER;
            if (status.cnt == CORDIC_LAST) begin
               state_in = ST_HDG_WRITE;
            end
         end
         ST_HDG_WRITE: begin
            cmd.op   = OP_HDG_WRITE;
            state_in = ST_FINISH;
         end
         ST_TURN: begin
            cmd.op   = OP_TURN;
            state_in = ST_ALIGN;
         end
         ST_ALIGN: begin
            if (status.aligned) begin
               cmd.op   = OP_DIFF;
               state_in = ST_SQ_X;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SQ_X: begin
            cmd.op   = OP_SQ_X;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            cmd.op   = OP_SQ_Y;
            state_in = ST_SQ_S;
         end
         ST_SQ_S: begin
            cmd.op   = OP_SQ_S;
            state_in = ST_SNAP;
         end
         ST_SNAP: begin
            if (status.snap) begin
               cmd.op   = OP_SNAP;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_SQRT_INIT;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.op = OP_SQRT;
            if (status.cnt == SQRT_LAST) begin
               state_in = ST_DIV_MUL_X;
            end
         end
         ST_DIV_MUL_X: begin
            if (status.norm_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_DIV_MUL_X;
               state_in = ST_DIV_INIT_X;
            end
         end
         ST_DIV_INIT_X: begin
            cmd.op   = OP_DIV_INIT;
            state_in = ST_DIV_X;
         end
         ST_DIV_X: begin
            cmd.op = OP_DIV;
            if (status.cnt == DIV_LAST) begin
               state_in = ST_ADD_X;
            end
         end
         ST_ADD_X: begin
            cmd.op   = OP_ADD_X;
            state_in = ST_DIV_MUL_Y;
         end
         ST_DIV_MUL_Y: begin
            cmd.op   = OP_DIV_MUL_Y;
            state_in = ST_DIV_INIT_Y;
         end
         ST_DIV_INIT_Y: begin
            cmd.op   = OP_DIV_INIT;
            state_in = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            cmd.op = OP_DIV;
            if (status.cnt == DIV_LAST) begin
               state_in = ST_ADD_Y;
            end
         end
         ST_ADD_Y: begin
            cmd.op   = OP_ADD_Y;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `TTM_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, state_ff == ST_EXEC, "accept did not start work")
   `TTM_ASSERT_NEXT(a_out_loads, cmd.op == OP_OUT, rsp_valid_ff, "result word not presented")
   `TTM_ASSERT_NOW(a_sqrt_bound, state_ff == ST_SQRT, status.cnt <= SQRT_LAST, "root step count overrun")
   `TTM_ASSERT_NOW(a_div_bound, state_ff == ST_DIV_X || state_ff == ST_DIV_Y, status.cnt <= DIV_LAST, "divide step count overrun")

endmodule

// File: hw/rtl/turn_then_move_waypoint_follower.sv
// ----------------------------------------------------------------------------
// turn_then_move_waypoint_follower
// turn-rate-limited waypoint steering with fixed-point position and heading
// ----------------------------------------------------------------------------
// One word in gives one result word out. A set-position or set-destination word
// pre-scales the offset (one doubling a cycle, up to 40) and then runs the
// 18-step cordic, or skips both when the offset is zero. A tick that moves runs
// the 34-step square root and one 32-step divider once per axis on a shared
// 32x32 multiplier; a tick can instead snap to the destination, only turn, or
// find the unit arrived. One word is worked at a time; the next word is taken
// while a finished result still waits.
module turn_then_move_waypoint_follower (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ttm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ttm_pkg::rsp_type rsp_data
);
   import ttm_pkg::*;

   cmd_type    cmd;
   status_type status;

   ttm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ttm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench for turn_then_move_waypoint_follower
// drives set-position, set-destination, set-heading and tick words with random
// gaps and back-pressure, predicts every result word and compares it as a whole
// word against the block's output
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import ttm_pkg::*;

   localparam longint CYCLE_LIMIT = 3000000;
   localparam longint LIM40 = 64'sd1 << 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   turn_then_move_waypoint_follower dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // predicted follower state
   longint      pos_x_m, pos_y_m, dst_x_m, dst_y_m;
   logic [15:0] hdg_m, dst_hdg_m;

   rsp_type     expected_words[$];
   int          mismatches = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   int          moves_seen = 0;
   int          hold_cycles = 0;
   bit          quiet = 1'b0;
   longint      cycles = 0;

   logic [31:0] atan_angles[18] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F
   };

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint absl(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void aim_heading();
      longint      x, y, xs, ys;
      logic [31:0] z;
      logic [31:0] zr;
      x = dst_y_m - pos_y_m;
      y = -(dst_x_m - pos_x_m);
      z = 32'h0;
      if (x == 0 && y == 0) return;
      while (absl(x) < LIM40 && absl(y) < LIM40) begin
         x = x * 2;
         y = y * 2;
      end
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h80000000;
      end
      for (int i = 0; i < 18; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + atan_angles[i];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_angles[i];
         end
      end
      zr = z + 32'h8000;
      dst_hdg_m = zr[31:16];
   endfunction

   function automatic void turn_toward(logic [15:0] ts);
      int c, d, t, ad;
      c = hdg_m;
      d = dst_hdg_m;
      t = ts;
      ad = d - c;
      if (ad < 0) ad = -ad;
      if (ad <= 32768) begin
         if (ad < t) c = d;
         else c = c + ((d > c) ? t : -t);
      end else begin
         if (65536 - ad < t) c = d;
         else c = c + ((d > c) ? -t : t);
      end
      hdg_m = c[15:0];
   endfunction

   function automatic void advance(logic [30:0] ms);
      longint           dx, dy;
      logic [127:0]     ax, ay, s, step, nrm, cand, q;
      dx = dst_x_m - pos_x_m;
      dy = dst_y_m - pos_y_m;
      ax = 128'(absl(dx));
      ay = 128'(absl(dy));
      step = 128'(ms);
      s = ax * ax + ay * ay;
      if (s < step * step) begin
         pos_x_m = dst_x_m;
         pos_y_m = dst_y_m;
         return;
      end
      nrm = 0;
      for (int b = 33; b >= 0; b--) begin
         cand = nrm | (128'd1 << b);
         if (cand * cand <= s) nrm = cand;
      end
      if (nrm == 0) return;
      moves_seen++;
      q = (ax * step) / nrm;
      pos_x_m = pos_x_m + (dx < 0 ? -longint'(q[63:0]) : longint'(q[63:0]));
      q = (ay * step) / nrm;
      pos_y_m = pos_y_m + (dy < 0 ? -longint'(q[63:0]) : longint'(q[63:0]));
   endfunction

   function automatic bit at_target();
      return pos_x_m == dst_x_m && pos_y_m == dst_y_m;
   endfunction

   function automatic rsp_type follow_step(req_type w);
      rsp_type r;
      case (w.kind)
         KIND_TICK: begin
            if (!at_target()) begin
               turn_toward(w.turn_step);
               if (hdg_m == dst_hdg_m) advance(w.move_step);
            end
         end
         KIND_SET_POS: begin
            pos_x_m = longint'(w.coord_x);
            pos_y_m = longint'(w.coord_y);
            aim_heading();
         end
         KIND_SET_DST: begin
            dst_x_m = longint'(w.coord_x);
            dst_y_m = longint'(w.coord_y);
            aim_heading();
         end
         default: begin
            hdg_m = w.new_heading;
            dst_hdg_m = w.new_heading;
            dst_x_m = pos_x_m;
            dst_y_m = pos_y_m;
         end
      endcase
      r.pos_x = pos_x_m[31:0];
      r.pos_y = pos_y_m[31:0];
      r.heading = hdg_m;
      r.arrived = at_target();
      return r;
   endfunction

   task automatic send_word(req_type w);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 33) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_valid = 1'b1;
      req_data = w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(follow_step(w));
      words_sent++;
      @(negedge clock);
   endtask

   function automatic req_type make_word(logic [1:0] k, int x, int y,
                                         logic [15:0] ts, logic [30:0] ms,
                                         logic [15:0] nh);
      req_type w;
      w.kind = k;
      w.coord_x = x;
      w.coord_y = y;
      w.turn_step = ts;
      w.move_step = ms;
      w.new_heading = nh;
      return w;
   endfunction

   function automatic int rand_coord();
      int v;
      v = $urandom;
      return v >>> $urandom_range(0, 31);
   endfunction

   function automatic req_type rand_word();
      req_type w;
      w = req_type'(129'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      return w;
   endfunction

   // receiver stall, with a long hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall = quiet ? 1'b0 : ($urandom_range(0, 99) < 33);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: x=%h y=%h hdg=%h arr=%b",
                        rsp_data.pos_x, rsp_data.pos_y, rsp_data.heading,
                        rsp_data.arrived);
         end else begin
            e = expected_words.pop_front();
            words_checked++;
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("mismatch word %0d: exp x=%h y=%h hdg=%h arr=%b ",
                         words_checked, e.pos_x, e.pos_y, e.heading, e.arrived);
                  $display("got x=%h y=%h hdg=%h arr=%b",
                           rsp_data.pos_x, rsp_data.pos_y, rsp_data.heading,
                           rsp_data.arrived);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench failed");
         $finish;
      end
   end

   task automatic test_extremes();
      send_word(make_word(KIND_TICK, 0, 0, 16'hFFFF, 31'h7FFFFFFF, 16'hFFFF));
      send_word(make_word(KIND_SET_POS, 32'h80000000, 32'h80000000, 0, 0, 0));
      send_word(make_word(KIND_SET_DST, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0));
      send_word(make_word(KIND_TICK, 0, 0, 16'd32768, 31'h7FFFFFFF, 0));
      send_word(make_word(KIND_TICK, 0, 0, 16'd32768, 31'h7FFFFFFF, 0));
      send_word(make_word(KIND_SET_DST, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0));
      send_word(make_word(KIND_TICK, 0, 0, 16'hFFFF, 31'h7FFFFFFF, 0));
   endtask

   task automatic test_set_heading();
      send_word(make_word(KIND_SET_HDG, 5, 7, 16'd3, 31'd9, 16'hFFFF));
      send_word(make_word(KIND_TICK, 0, 0, 16'd100, 31'd100, 0));
      send_word(make_word(KIND_SET_HDG, 0, 0, 0, 0, 16'h0000));
   endtask

   task automatic test_zero_vector();
      send_word(make_word(KIND_SET_POS, 32'h10000, 32'h20000, 0, 0, 0));
      send_word(make_word(KIND_SET_DST, 32'h10000, 32'h20000, 0, 0, 0));
      send_word(make_word(KIND_SET_HDG, 0, 0, 0, 0, 16'h1234));
      send_word(make_word(KIND_SET_DST, 32'h10000, 32'h20000, 0, 0, 0));
   endtask

   task automatic test_turns();
      // destination straight behind: half a turn apart
      send_word(make_word(KIND_SET_HDG, 0, 0, 0, 0, 16'h0000));
      send_word(make_word(KIND_SET_DST, 32'h10000, 32'h0, 0, 0, 0));
      send_word(make_word(KIND_SET_DST, 32'h0, 32'hFFF00000, 0, 0, 0));
      send_word(make_word(KIND_TICK, 0, 0, 16'd0, 31'd65536, 0));
      send_word(make_word(KIND_TICK, 0, 0, 16'd1000, 31'd65536, 0));
      send_word(make_word(KIND_TICK, 0, 0, 16'd40000, 31'd65536, 0));
      send_word(make_word(KIND_TICK, 0, 0, 16'd0, 31'd65536, 0));
      send_word(make_word(KIND_TICK, 0, 0, 16'd0, 31'h7FFFFFFF, 0));
      send_word(make_word(KIND_TICK, 0, 0, 16'd0, 31'd0, 0));
   endtask

   task automatic test_backpressure();
      hold_cycles = 600;
      for (int i = 0; i < 12; i++) begin
         send_word(make_word(KIND_SET_DST, rand_coord(), rand_coord(), 0, 0, 0));
         send_word(make_word(KIND_TICK, 0, 0, 16'($urandom_range(0, 65535)),
                             31'($urandom), 0));
      end
   endtask

   task automatic test_random_routes(int target);
      req_type w;
      int      n;
      while (words_sent < target) begin
         if (words_sent > target / 2 && words_sent < target / 2 + 200) quiet = 1'b1;
         else quiet = 1'b0;
         if ($urandom_range(0, 99) < 75) begin
            send_word(make_word(KIND_SET_POS, rand_coord(), rand_coord(),
                                16'($urandom), 31'($urandom), 16'($urandom)));
            if ($urandom_range(0, 9) == 0)
               send_word(make_word(KIND_SET_HDG, $urandom, $urandom, 0, 0,
                                   16'($urandom)));
            send_word(make_word(KIND_SET_DST, rand_coord(), rand_coord(),
                                16'($urandom), 31'($urandom), 16'($urandom)));
            n = $urandom_range(2, 30);
            for (int i = 0; i < n && !at_target(); i++) begin
               w = make_word(KIND_TICK, $urandom, $urandom,
                             16'($urandom_range(0, 99) < 90 ? $urandom_range(0, 16384)
                                                            : $urandom_range(0, 65535)),
                             31'($urandom >> $urandom_range(1, 31)), 16'($urandom));
               send_word(w);
            end
         end else begin
            send_word(rand_word());
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      pos_x_m = 0; pos_y_m = 0; dst_x_m = 0; dst_y_m = 0;
      hdg_m = 0; dst_hdg_m = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_set_heading();
      test_zero_vector();
      test_turns();
      test_backpressure();
      test_random_routes(1950);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d words, checked %0d results, %0d partial moves, %0d mismatches",
               words_sent, words_checked, moves_seen, mismatches);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
